/* rtl/core/fic_pkg.sv */
// shared types, constants and helpers of the fuzzy image compare block
package fic_pkg;

	localparam int PIX_W           = 32;
	localparam int CHAN_W          = 8;
	localparam int DIM_W           = 13;
	localparam int DIFF_W          = 8;
	localparam int BOUND_W         = 32;
	localparam int COUNT_W         = 25;
	localparam int AREA_W          = 2 * DIM_W;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int MAX_DIM_DEFAULT = 4096;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [DIFF_W-1:0]  DIFF_MISMATCH = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTUAL_WIDTH,
		CFG_ACTUAL_HEIGHT,
		CFG_EXPECTED_WIDTH,
		CFG_EXPECTED_HEIGHT,
		CFG_MAX_DIFF_LOW,
		CFG_MAX_DIFF_HIGH,
		CFG_COUNT_LOW,
		CFG_COUNT_HIGH
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] actual_pixel;
		logic [PIX_W-1:0] expected_pixel;
		logic             pixel_valid;
		logic             last;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] diff_pixel_count;
		logic [DIFF_W-1:0]  max_channel_diff;
		logic               pass;
	} out_item_t;

	// classified item between front and back
	typedef struct packed {
		logic [DIFF_W-1:0] worst;
		logic              last;
	} qentry_t;

	typedef struct packed {
		logic [DIM_W-1:0]   actual_width;
		logic [DIM_W-1:0]   actual_height;
		logic [DIM_W-1:0]   expected_width;
		logic [DIM_W-1:0]   expected_height;
		logic [DIFF_W-1:0]  max_diff_low;
		logic [DIFF_W-1:0]  max_diff_high;
		logic [BOUND_W-1:0] count_low;
		logic [BOUND_W-1:0] count_high;
	} cfg_t;

	function automatic logic [CHAN_W-1:0] abs_diff8(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

/* rtl/core/fic_front.sv */
// front end: takes pixel pairs and reduces each to its worst rgb difference
module fic_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  fic_pkg::in_item_t in_item,
	input  logic             q_full,
	output logic             q_push,
	output fic_pkg::qentry_t q_entry
);
	import fic_pkg::*;

	logic [CHAN_W-1:0] dr, dg, db, wrg, w;

	assign dr = abs_diff8(in_item.actual_pixel[23:16], in_item.expected_pixel[23:16]);
	assign dg = abs_diff8(in_item.actual_pixel[15:8], in_item.expected_pixel[15:8]);
	assign db = abs_diff8(in_item.actual_pixel[7:0], in_item.expected_pixel[7:0]);
	assign wrg = (dg > dr) ? dg : dr;
	assign w = (db > wrg) ? db : wrg;

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	// close-only items carry no difference; alpha is never looked at
	assign q_entry.worst = in_item.pixel_valid ? w : '0;
	assign q_entry.last = in_item.last;

endmodule

/* rtl/core/fic_queue.sv */
// short fifo between the front end and the accumulator
module fic_queue #(
	parameter int DEPTH = fic_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fic_pkg::qentry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output fic_pkg::qentry_t rd_entry,
	output logic             empty
);
	import fic_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qentry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/fic_back.sv */
// back end: accumulates count and worst difference, forms the verdict
module fic_back #(
	parameter int MAX_DIM = fic_pkg::MAX_DIM_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fic_pkg::cfg_t     cfg,
	input  logic              q_empty,
	input  fic_pkg::qentry_t  q_entry,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output fic_pkg::out_item_t out_item
);
	import fic_pkg::*;

	localparam int DIM_LIMIT = (1 << DIM_W) - 1;
	localparam int DIM_CAP = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
	localparam logic [DIM_W-1:0] CAP = DIM_W'(DIM_CAP);

	logic [DIM_W-1:0]   aw_c, ah_c, ew_c, eh_c;
	logic [AREA_W-1:0]  area_a_q, area_e_q, bigger;
	logic               mismatch_q;
	logic [COUNT_W-1:0] big_q;

	logic [COUNT_W-1:0] count_q, cnt_next;
	logic [DIFF_W-1:0]  worst_q, worst_next;

	logic               valid_s2;
	logic [COUNT_W-1:0] count_s2;
	logic [DIFF_W-1:0]  worst_s2;

	logic               out_valid_q;
	out_item_t          out_item_q;
	logic               out_load, s2_free;
	logic [COUNT_W-1:0] fin_count;
	logic [DIFF_W-1:0]  fin_worst;
	logic               exact, fin_pass;
	logic [BOUND_W-1:0] fin_count_ext;

	// size check from the dimension registers, kept current every cycle
	assign aw_c = (cfg.actual_width > CAP) ? CAP : cfg.actual_width;
	assign ah_c = (cfg.actual_height > CAP) ? CAP : cfg.actual_height;
	assign ew_c = (cfg.expected_width > CAP) ? CAP : cfg.expected_width;
	assign eh_c = (cfg.expected_height > CAP) ? CAP : cfg.expected_height;
	assign bigger = (area_a_q > area_e_q) ? area_a_q : area_e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_a_q <= '0;
			area_e_q <= '0;
			mismatch_q <= 1'b0;
			big_q <= '0;
		end else begin
			area_a_q <= {{DIM_W{1'b0}}, aw_c} * {{DIM_W{1'b0}}, ah_c};
			area_e_q <= {{DIM_W{1'b0}}, ew_c} * {{DIM_W{1'b0}}, eh_c};
			mismatch_q <= (aw_c != ew_c) || (ah_c != eh_c);
			big_q <= (bigger[AREA_W-1:COUNT_W] != '0) ? COUNT_MAX : bigger[COUNT_W-1:0];
		end
	end

	// accumulate stage
	assign out_load = !out_valid_q || out_ready;
	assign s2_free = !valid_s2 || out_load;
	assign q_pop = !q_empty && (!q_entry.last || s2_free);
	assign cnt_next = (q_entry.worst != '0 && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign worst_next = (q_entry.worst > worst_q) ? q_entry.worst : worst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			worst_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_entry.last) begin
					count_q <= '0;
					worst_q <= '0;
				end else begin
					count_q <= cnt_next;
					worst_q <= worst_next;
				end
			end
			if (q_pop && q_entry.last) begin
				valid_s2 <= 1'b1;
			end else if (out_load) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.last) begin
			count_s2 <= cnt_next;
			worst_s2 <= worst_next;
		end
	end

	// verdict stage
	assign fin_count = mismatch_q ? big_q : count_s2;
	assign fin_worst = mismatch_q ? DIFF_MISMATCH : worst_s2;
	assign fin_count_ext = {{(BOUND_W - COUNT_W){1'b0}}, fin_count};
	assign exact = (cfg.max_diff_low == '0) && (cfg.max_diff_high == '0) &&
		(cfg.count_low == '0) && (cfg.count_high == '0);

	always_comb begin
		if (exact) begin
			fin_pass = (fin_count == '0);
		end else begin
			fin_pass = ((fin_count == '0) && (cfg.count_low == '0)) ||
				((fin_worst == '0) && (cfg.max_diff_low == '0)) ||
				((cfg.max_diff_low <= fin_worst) && (fin_worst <= cfg.max_diff_high) &&
				(cfg.count_low <= fin_count_ext) && (fin_count_ext <= cfg.count_high));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			out_item_q.diff_pixel_count <= fin_count;
			out_item_q.max_channel_diff <= fin_worst;
			out_item_q.pass <= fin_pass;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

/* rtl/core/fuzzy_image_compare_core.sv */
// top level of the fuzzy image compare block
//
// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     in_item (fic_pkg::in_item_t)
// out       source     out_valid / out_ready   out_item (fic_pkg::out_item_t)
// cfg       sink       cfg_we, no wait         cfg_index, cfg_data
//
// one pixel pair is taken every cycle while the queue has room
// a result passes the queue, the accumulator stage and the verdict register before it is offered
// out_ready low fills the verdict register, then the accumulator stage; the queue backs up once a last item
// reaches its head, and only then drops in_ready
// arst_n clears the queue, accumulators and the configuration registers
// size check follows a configuration write through the area and mismatch registers, then the size count register
module fuzzy_image_compare_core #(
	parameter int MAX_DIM = fic_pkg::MAX_DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  fic_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fic_pkg::out_item_t             out_item,
	input  logic                           cfg_we,
	input  logic [fic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fic_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fic_pkg::*;

	cfg_t    cfg_q;
	logic    q_full, q_push, q_pop, q_empty;
	qentry_t q_wr_entry, q_rd_entry;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ACTUAL_WIDTH: begin
					cfg_q.actual_width <= cfg_data[DIM_W-1:0];
				end
				CFG_ACTUAL_HEIGHT: begin
					cfg_q.actual_height <= cfg_data[DIM_W-1:0];
				end
				CFG_EXPECTED_WIDTH: begin
					cfg_q.expected_width <= cfg_data[DIM_W-1:0];
				end
				CFG_EXPECTED_HEIGHT: begin
					cfg_q.expected_height <= cfg_data[DIM_W-1:0];
				end
				CFG_MAX_DIFF_LOW: begin
					cfg_q.max_diff_low <= cfg_data[DIFF_W-1:0];
				end
				CFG_MAX_DIFF_HIGH: begin
					cfg_q.max_diff_high <= cfg_data[DIFF_W-1:0];
				end
				CFG_COUNT_LOW: begin
					cfg_q.count_low <= cfg_data[BOUND_W-1:0];
				end
				CFG_COUNT_HIGH: begin
					cfg_q.count_high <= cfg_data[BOUND_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front: per-pair channel differences, reduced to one worst value
	fic_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_wr_entry)
	);

	// decoupling queue so the front keeps streaming while the back is held
	fic_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.empty    (q_empty)
	);

	// back: saturating count, running maximum, size check and verdict
	fic_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_entry   (q_rd_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

/* rtl/core/fic_checker.sv */
// port-level checks of the fuzzy image compare block, bound to the top level
module fic_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input fic_pkg::out_item_t             out_item,
	input logic                           cfg_we,
	input logic [fic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [fic_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fic_pkg::*;

	logic [BOUND_W-1:0] count_low_q;

	// shadow of the lower count bound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_low_q <= '0;
		end else if (cfg_we && cfg_reg_t'(cfg_index) == CFG_COUNT_LOW) begin
			count_low_q <= cfg_data[BOUND_W-1:0];
		end
	end

	// a held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// away from a size mismatch, a counted pixel carries a nonzero difference and back
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.max_channel_diff != DIFF_MISMATCH |->
		((out_item.diff_pixel_count == '0) == (out_item.max_channel_diff == '0)))
		else $error("count and worst difference disagree");

	// no differing pixel with a zero lower count bound always passes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.diff_pixel_count == '0 && count_low_q == '0 |->
		out_item.pass)
		else $error("clean comparison reported as fail");

endmodule

bind fuzzy_image_compare_core fic_checker u_fic_checker (.*);
